// ===== rtl/jsfr_pkg.sv =====
// jsfr_pkg: shared types and constants of the joint status frame receiver
// no dependencies; used by every module of the block

package jsfr_pkg;

    localparam int JSFR_JOINT_COUNT = 12;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int JIDX_W   = 4;
    localparam int VALUE_W  = 16;

    localparam logic [BYTE_W-1:0] HEADER_RST = 8'h7B;
    localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h7D;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_TAIL  = 2'd1,
        STS_BAD_CHECK = 2'd2
    } t_status;

    // frame end notice from the collector to the result sequencer
    typedef struct packed {
        logic    start;
        t_status status;
    } t_frame_end;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_LOAD,
        EM_SHOW
    } t_emit_state;

endpackage

// ===== rtl/jsfr_in_if.sv =====
// jsfr_in_if: input channel, one received serial byte per transfer
// depends on jsfr_pkg for the byte width

interface jsfr_in_if import jsfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/jsfr_out_if.sv =====
// jsfr_out_if: result channel, one joint entry or one error per transfer
// depends on jsfr_pkg for field widths

interface jsfr_out_if import jsfr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [JIDX_W-1:0]         joint_index;
    logic signed [VALUE_W-1:0] joint_angle;
    logic signed [VALUE_W-1:0] joint_speed;
    logic [BYTE_W-1:0]         stop_flag;
    logic                      last;

    modport source (output valid, output status, output joint_index, output joint_angle,
                    output joint_speed, output stop_flag, output last, input ready);
    modport sink   (input valid, input status, input joint_index, input joint_angle,
                    input joint_speed, input stop_flag, input last, output ready);
endinterface

// ===== rtl/joint_status_frame_receiver.sv =====
// Joint status frame receiver: deframes header, stop byte, JOINT_COUNT
// big-endian int16 angles and speeds, xor check byte and tail, one byte per
// transfer. While a frame is collected a byte is taken every cycle. After the
// tail byte the input stalls while results go out: an error gives one result
// in the cycle right after the tail; a good frame gives JOINT_COUNT results,
// each by a word memory read, an output register load and a transfer, one
// joint at a time, set by the single read port of the angle/speed memories.
// Reads and writes of the memories never overlap in time.
// depends on jsfr_pkg, jsfr_in_if, jsfr_out_if, jsfr_collect, jsfr_store, jsfr_emit

module joint_status_frame_receiver import jsfr_pkg::*; #(
    parameter int JOINT_COUNT = JSFR_JOINT_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    jsfr_in_if.sink              i_rx,
    jsfr_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    logic                      w_we_angle;
    logic                      w_we_speed;
    logic [AW-1:0]             w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic                      w_re;
    logic [AW-1:0]             w_raddr;
    logic signed [VALUE_W-1:0] w_angle;
    logic signed [VALUE_W-1:0] w_speed;
    logic [BYTE_W-1:0]         w_stop;
    logic                      w_busy;
    t_frame_end                w_end;

    jsfr_collect #(.JOINT_COUNT(JOINT_COUNT)) u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_busy     (w_busy),
        .o_we_angle (w_we_angle),
        .o_we_speed (w_we_speed),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_stop     (w_stop),
        .o_end      (w_end)
    );

    jsfr_store #(.JOINT_COUNT(JOINT_COUNT)) u_store (
        .i_clk      (i_clk),
        .i_we_angle (w_we_angle),
        .i_we_speed (w_we_speed),
        .i_waddr    (w_waddr),
        .i_wdata    (w_wdata),
        .i_re       (w_re),
        .i_raddr    (w_raddr),
        .o_angle    (w_angle),
        .o_speed    (w_speed)
    );

    jsfr_emit #(.JOINT_COUNT(JOINT_COUNT)) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_end   (w_end),
        .i_stop  (w_stop),
        .i_angle (w_angle),
        .i_speed (w_speed),
        .o_re    (w_re),
        .o_raddr (w_raddr),
        .o_busy  (w_busy),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/jsfr_store.sv =====
// jsfr_store: angle and speed word memories, one write and one read port each
// depends on jsfr_pkg; read data registered

module jsfr_store import jsfr_pkg::*; #(
    parameter int JOINT_COUNT = JSFR_JOINT_COUNT,
    localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we_angle,
    input  logic                      i_we_speed,
    input  logic [AW-1:0]             i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic signed [VALUE_W-1:0] o_angle,
    output logic signed [VALUE_W-1:0] o_speed
);

    logic signed [VALUE_W-1:0] r_angle_mem [JOINT_COUNT];
    logic signed [VALUE_W-1:0] r_speed_mem [JOINT_COUNT];
    logic signed [VALUE_W-1:0] r_angle;
    logic signed [VALUE_W-1:0] r_speed;

    always_ff @(posedge i_clk) begin
        if (i_we_angle) begin
            r_angle_mem[i_waddr] <= i_wdata;
        end
        if (i_we_speed) begin
            r_speed_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_angle <= r_angle_mem[i_raddr];
            r_speed <= r_speed_mem[i_raddr];
        end
    end

    assign o_angle = r_angle;
    assign o_speed = r_speed;

endmodule

// ===== rtl/jsfr_collect.sv =====
// jsfr_collect: frame position tracking, xor check, config registers,
// word assembly into the store; depends on jsfr_pkg and jsfr_in_if

module jsfr_collect import jsfr_pkg::*; #(
    parameter int JOINT_COUNT = JSFR_JOINT_COUNT,
    localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    jsfr_in_if.sink                   i_rx,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [BYTE_W-1:0]         i_cfg_data,
    input  logic                      i_busy,
    output logic                      o_we_angle,
    output logic                      o_we_speed,
    output logic [AW-1:0]             o_waddr,
    output logic signed [VALUE_W-1:0] o_wdata,
    output logic [BYTE_W-1:0]         o_stop,
    output t_frame_end                o_end
);

    localparam int POS_W = $clog2(4 * JOINT_COUNT + 4);
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(4 * JOINT_COUNT + 2);
    localparam logic [POS_W-1:0] TAIL_POS  = POS_W'(4 * JOINT_COUNT + 3);
    localparam logic [POS_W-1:0] STOP_POS  = POS_W'(1);
    localparam logic [POS_W-1:0] DATA_POS  = POS_W'(2);

    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_tail;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] r_check;
    logic [BYTE_W-1:0] n_check;
    logic              r_match;
    logic              n_match;
    logic [BYTE_W-1:0] r_stop;
    logic [BYTE_W-1:0] r_hi;

    logic              w_acc;
    logic [BYTE_W-1:0] w_byte;
    logic              w_in_data;
    logic [POS_W-1:0]  w_off;
    logic [POS_W-2:0]  w_word;
    logic [POS_W-2:0]  w_speed_word;
    logic              w_is_angle;
    logic              w_word_done;

    assign i_rx.ready = ~i_busy;
    assign w_acc      = i_rx.valid & ~i_busy;
    assign w_byte     = i_rx.rx_byte;

    // byte offset into the payload and the big-endian word it belongs to
    assign w_in_data    = (r_pos >= DATA_POS) && (r_pos < CHECK_POS);
    assign w_off        = r_pos - DATA_POS;
    assign w_word       = w_off[POS_W-1:1];
    assign w_speed_word = w_word - (POS_W-1)'(JOINT_COUNT);
    assign w_is_angle   = w_word < (POS_W-1)'(JOINT_COUNT);
    assign w_word_done  = w_acc & w_in_data & w_off[0];

    assign o_we_angle = w_word_done & w_is_angle;
    assign o_we_speed = w_word_done & ~w_is_angle;
    assign o_waddr    = w_is_angle ? AW'(w_word) : AW'(w_speed_word);
    assign o_wdata    = {r_hi, w_byte};
    assign o_stop     = r_stop;

    always_comb begin
        n_pos   = r_pos;
        n_check = r_check;
        n_match = r_match;
        if (w_acc) begin
            priority if (r_pos == '0) begin
                if (w_byte == r_header) begin
                    n_check = w_byte;
                    n_match = 1'b0;
                    n_pos   = STOP_POS;
                end
            end else if (r_pos < CHECK_POS) begin
                n_check = r_check ^ w_byte;
                n_pos   = r_pos + 1'b1;
            end else if (r_pos == CHECK_POS) begin
                n_match = (w_byte == r_check);
                n_pos   = r_pos + 1'b1;
            end else begin
                n_pos = '0;
            end
        end
    end

    always_comb begin
        o_end.start  = w_acc && (r_pos == TAIL_POS);
        o_end.status = STS_OK;
        // tail is tested before the check byte
        if (w_byte != r_tail) begin
            o_end.status = STS_BAD_TAIL;
        end else if (!r_match) begin
            o_end.status = STS_BAD_CHECK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RST;
            r_tail   <= TAIL_RST;
            r_pos    <= '0;
            r_check  <= '0;
            r_match  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEADER) begin
                    r_header <= i_cfg_data;
                end else if (i_cfg_idx == CFG_TAIL) begin
                    r_tail <= i_cfg_data;
                end
            end
            r_pos   <= n_pos;
            r_check <= n_check;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (r_pos == STOP_POS)) begin
            r_stop <= w_byte;
        end
        if (w_acc && w_in_data && !w_off[0]) begin
            r_hi <= w_byte;
        end
    end

endmodule

// ===== rtl/jsfr_emit.sv =====
// jsfr_emit: result sequencer, reads the store joint by joint into the
// output register; depends on jsfr_pkg and jsfr_out_if

module jsfr_emit import jsfr_pkg::*; #(
    parameter int JOINT_COUNT = JSFR_JOINT_COUNT,
    localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_frame_end                i_end,
    input  logic [BYTE_W-1:0]         i_stop,
    input  logic signed [VALUE_W-1:0] i_angle,
    input  logic signed [VALUE_W-1:0] i_speed,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    output logic                      o_busy,
    jsfr_out_if.source                o_res
);

    localparam logic [AW-1:0] LAST_IDX = AW'(JOINT_COUNT - 1);

    t_emit_state r_state;
    t_emit_state n_state;
    logic [AW-1:0] r_idx;

    t_status                   r_status;
    logic [JIDX_W-1:0]         r_jidx;
    logic signed [VALUE_W-1:0] r_angle;
    logic signed [VALUE_W-1:0] r_speed;
    logic [BYTE_W-1:0]         r_stop;
    logic                      r_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EM_IDLE: begin
                if (i_end.start) begin
                    n_state = (i_end.status == STS_OK) ? EM_READ : EM_SHOW;
                end
            end
            EM_READ: n_state = EM_LOAD;
            EM_LOAD: n_state = EM_SHOW;
            EM_SHOW: begin
                if (o_res.ready) begin
                    n_state = r_last ? EM_IDLE : EM_READ;
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_comb begin
        o_re        = (r_state == EM_READ);
        o_busy      = (r_state != EM_IDLE);
        o_res.valid = (r_state == EM_SHOW);
    end

    assign o_raddr           = r_idx;
    assign o_res.status      = r_status;
    assign o_res.joint_index = r_jidx;
    assign o_res.joint_angle = r_angle;
    assign o_res.joint_speed = r_speed;
    assign o_res.stop_flag   = r_stop;
    assign o_res.last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == EM_IDLE) begin
                r_idx <= '0;
            end else if ((r_state == EM_SHOW) && o_res.ready && !r_last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // error results load at frame end, joint results after each memory read
    always_ff @(posedge i_clk) begin
        if ((r_state == EM_IDLE) && i_end.start) begin
            r_status <= i_end.status;
            r_jidx   <= '0;
            r_angle  <= '0;
            r_speed  <= '0;
            r_stop   <= '0;
            r_last   <= 1'b1;
        end else if (r_state == EM_LOAD) begin
            r_status <= STS_OK;
            r_jidx   <= JIDX_W'(r_idx);
            r_angle  <= i_angle;
            r_speed  <= i_speed;
            r_stop   <= i_stop;
            r_last   <= (r_idx == LAST_IDX);
        end
    end

endmodule
